FILE: rtl/dlcc_pkg.sv
package dlcc_pkg;

    // Function codes carried by the func field.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_OPEN   = 2'd1;
    localparam logic [1:0] FUNC_CHANGE = 2'd2;
    localparam logic [1:0] FUNC_NEW    = 2'd3;

    // Response codes.
    localparam logic [1:0] RESP_TICK     = 2'd0;
    localparam logic [1:0] RESP_MATCH    = 2'd1;
    localparam logic [1:0] RESP_MISMATCH = 2'd2;
    localparam logic [1:0] RESP_IGNORED  = 2'd3;

    // Motor drive codes.
    localparam logic [1:0] MOTOR_STOP     = 2'd0;
    localparam logic [1:0] MOTOR_FORWARD  = 2'd1;
    localparam logic [1:0] MOTOR_BACKWARD = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CODE_MAX_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS  = 3'd4;

    // Register reset values.
    localparam logic [2:0] MAX_ATTEMPTS_RST = 3'd3;
    localparam logic [7:0] OPEN_TICKS_RST   = 8'd15;
    localparam logic [7:0] HOLD_TICKS_RST   = 8'd3;
    localparam logic [7:0] CLOSE_TICKS_RST  = 8'd15;
    localparam logic [7:0] ALARM_TICKS_RST  = 8'd60;

    typedef struct packed {
        logic [2:0] max_attempts;
        logic [7:0] open_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] close_ticks;
        logic [7:0] alarm_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] response;
        logic [1:0] motor_drive;
        logic       alarm_sound;
        logic       awaiting_new_code;
        logic [2:0] failed_tries;
    } res_t;

endpackage

FILE: rtl/dlcc_cfg.sv
module dlcc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dlcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dlcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dlcc_pkg::cfg_t                   cfg
);

    dlcc_pkg::cfg_t cfg_reg;
    dlcc_pkg::cfg_t cfg_next;

    // Decode a register write; unknown indexes leave everything alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dlcc_pkg::REG_MAX_ATTEMPTS: cfg_next.max_attempts = cfg_data[2:0];
                dlcc_pkg::REG_OPEN_TICKS:   cfg_next.open_ticks   = cfg_data;
                dlcc_pkg::REG_HOLD_TICKS:   cfg_next.hold_ticks   = cfg_data;
                dlcc_pkg::REG_CLOSE_TICKS:  cfg_next.close_ticks  = cfg_data;
                dlcc_pkg::REG_ALARM_TICKS:  cfg_next.alarm_ticks  = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_attempts <= dlcc_pkg::MAX_ATTEMPTS_RST;
            cfg_reg.open_ticks   <= dlcc_pkg::OPEN_TICKS_RST;
            cfg_reg.hold_ticks   <= dlcc_pkg::HOLD_TICKS_RST;
            cfg_reg.close_ticks  <= dlcc_pkg::CLOSE_TICKS_RST;
            cfg_reg.alarm_ticks  <= dlcc_pkg::ALARM_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dlcc_in_reg.sv
module dlcc_in_reg
#(
    parameter int CODE_W = 40
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [dlcc_pkg::CODE_MAX_W-1:0]     typed_code,
    input  logic [dlcc_pkg::CODE_MAX_W-1:0]     confirm_code,
    output logic                                item_valid,
    input  logic                                item_take,
    output logic [1:0]                          item_func,
    output logic [CODE_W-1:0]                   item_typed,
    output logic [CODE_W-1:0]                   item_confirm
);

    logic              vld_reg;
    logic              vld_next;
    logic [1:0]        func_reg;
    logic [CODE_W-1:0] typed_reg;
    logic [CODE_W-1:0] confirm_reg;
    logic              load;

    // The register takes a new beat whenever it is empty or being drained.
    assign in_ready = !vld_reg || item_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (item_take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Only the code bytes that take part in the compare are kept.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg    <= func;
            typed_reg   <= typed_code[CODE_W-1:0];
            confirm_reg <= confirm_code[CODE_W-1:0];
        end
    end

    assign item_valid   = vld_reg;
    assign item_func    = func_reg;
    assign item_typed   = typed_reg;
    assign item_confirm = confirm_reg;

endmodule

FILE: rtl/dlcc_fsm.sv
module dlcc_fsm
#(
    parameter int CODE_W = 40
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlcc_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    output logic                 item_take,
    input  logic [1:0]           item_func,
    input  logic [CODE_W-1:0]    item_typed,
    input  logic [CODE_W-1:0]    item_confirm,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dlcc_pkg::res_t       res
);

    localparam logic [2:0] MODE_SETUP   = 3'd0;
    localparam logic [2:0] MODE_IDLE    = 3'd1;
    localparam logic [2:0] MODE_OPENING = 3'd2;
    localparam logic [2:0] MODE_HOLDING = 3'd3;
    localparam logic [2:0] MODE_CLOSING = 3'd4;
    localparam logic [2:0] MODE_ALARM   = 3'd5;

    logic [2:0]        mode_reg;
    logic [2:0]        mode_next;
    logic [7:0]        phase_reg;
    logic [7:0]        phase_next;
    logic [2:0]        fail_reg;
    logic [2:0]        fail_next;
    logic [CODE_W-1:0] saved_reg;
    logic              save_code;
    logic              out_vld_reg;
    logic              out_vld_next;
    dlcc_pkg::res_t    res_reg;
    dlcc_pkg::res_t    res_next;

    logic [7:0]        phase_inc;
    logic [2:0]        fail_inc;
    logic [7:0]        open_len;
    logic [7:0]        close_len;
    logic [7:0]        alarm_len;
    logic              saved_match;

    // An item moves on when the result register is free or being drained.
    assign item_take = item_valid && (!out_vld_reg || out_ready);

    assign phase_inc   = phase_reg + 8'd1;
    assign fail_inc    = fail_reg + 3'd1;
    assign open_len    = (cfg.open_ticks == 8'd0) ? 8'd1 : cfg.open_ticks;
    assign close_len   = (cfg.close_ticks == 8'd0) ? 8'd1 : cfg.close_ticks;
    assign alarm_len   = (cfg.alarm_ticks == 8'd0) ? 8'd1 : cfg.alarm_ticks;
    assign saved_match = (item_typed == saved_reg);

    // Next lock state and response for the item in the input register.
    always_comb
    begin
        mode_next          = mode_reg;
        phase_next         = phase_reg;
        fail_next          = fail_reg;
        save_code          = 1'b0;
        res_next.response  = dlcc_pkg::RESP_IGNORED;

        unique case (item_func)
            dlcc_pkg::FUNC_TICK:
            begin
                res_next.response = dlcc_pkg::RESP_TICK;
                phase_next        = phase_inc;
                unique case (mode_reg)
                    MODE_OPENING:
                    begin
                        if (phase_inc >= open_len)
                        begin
                            phase_next = 8'd0;
                            mode_next  = (cfg.hold_ticks == 8'd0) ? MODE_CLOSING
                                                                  : MODE_HOLDING;
                        end
                    end
                    MODE_HOLDING:
                    begin
                        if (phase_inc >= cfg.hold_ticks)
                        begin
                            phase_next = 8'd0;
                            mode_next  = MODE_CLOSING;
                        end
                    end
                    MODE_CLOSING:
                    begin
                        if (phase_inc >= close_len)
                        begin
                            phase_next = 8'd0;
                            mode_next  = MODE_IDLE;
                        end
                    end
                    MODE_ALARM:
                    begin
                        if (phase_inc >= alarm_len)
                        begin
                            phase_next = 8'd0;
                            mode_next  = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = 8'd0;
                    end
                endcase
            end
            dlcc_pkg::FUNC_NEW:
            begin
                // A new code pair is only taken in setup.
                if (mode_reg == MODE_SETUP)
                begin
                    if (item_typed == item_confirm)
                    begin
                        save_code         = 1'b1;
                        mode_next         = MODE_IDLE;
                        phase_next        = 8'd0;
                        res_next.response = dlcc_pkg::RESP_MATCH;
                    end
                    else
                    begin
                        res_next.response = dlcc_pkg::RESP_MISMATCH;
                    end
                end
            end
            dlcc_pkg::FUNC_OPEN, dlcc_pkg::FUNC_CHANGE:
            begin
                // Open and change requests are checked against the stored code in idle.
                if (mode_reg == MODE_IDLE)
                begin
                    if (saved_match)
                    begin
                        fail_next         = 3'd0;
                        phase_next        = 8'd0;
                        mode_next         = (item_func == dlcc_pkg::FUNC_OPEN) ? MODE_OPENING
                                                                              : MODE_SETUP;
                        res_next.response = dlcc_pkg::RESP_MATCH;
                    end
                    else
                    begin
                        res_next.response = dlcc_pkg::RESP_MISMATCH;
                        if (fail_inc >= cfg.max_attempts)
                        begin
                            fail_next  = 3'd0;
                            phase_next = 8'd0;
                            mode_next  = MODE_ALARM;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                        end
                    end
                end
            end
        endcase

        // Status fields reflect the state after the update.
        if (mode_next == MODE_OPENING)
        begin
            res_next.motor_drive = dlcc_pkg::MOTOR_FORWARD;
        end
        else if (mode_next == MODE_CLOSING)
        begin
            res_next.motor_drive = dlcc_pkg::MOTOR_BACKWARD;
        end
        else
        begin
            res_next.motor_drive = dlcc_pkg::MOTOR_STOP;
        end
        res_next.alarm_sound       = (mode_next == MODE_ALARM);
        res_next.awaiting_new_code = (mode_next == MODE_SETUP);
        res_next.failed_tries      = fail_next;
    end

    // Result valid flag.
    always_comb
    begin
        if (item_take)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SETUP;
            phase_reg   <= 8'd0;
            fail_reg    <= 3'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (item_take)
            begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                fail_reg  <= fail_next;
            end
        end
    end

    // Stored code and result payload.
    always_ff @(posedge clk)
    begin
        if (item_take && save_code)
        begin
            saved_reg <= item_typed;
        end
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/door_lock_code_controller_top.sv
// Code lock controller.
// Path: an accepted input beat passes through the input register, then the lock
// state update writes it into the result register.
// Throughput: one item per cycle; a full result register stalls the input side.
// Reset: rst_n clears the lock to setup, both counters to zero and the
// configuration registers to their defaults; the stored code is unknown until set.
module door_lock_code_controller_top
#(
    parameter int CODE_BYTES = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dlcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlcc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [dlcc_pkg::CODE_MAX_W-1:0]     typed_code,
    input  logic [dlcc_pkg::CODE_MAX_W-1:0]     confirm_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          response,
    output logic [1:0]                          motor_drive,
    output logic                                alarm_sound,
    output logic                                awaiting_new_code,
    output logic [2:0]                          failed_tries
);

    // Only the low code bytes take part, never more than the field carries.
    localparam int CODE_W = (8 * CODE_BYTES < dlcc_pkg::CODE_MAX_W) ? 8 * CODE_BYTES
                                                                    : dlcc_pkg::CODE_MAX_W;

    dlcc_pkg::cfg_t    cfg;
    dlcc_pkg::res_t    res;
    logic              item_valid;
    logic              item_take;
    logic [1:0]        item_func;
    logic [CODE_W-1:0] item_typed;
    logic [CODE_W-1:0] item_confirm;

    dlcc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlcc_in_reg #(.CODE_W(CODE_W)) u_in_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .typed_code   (typed_code),
        .confirm_code (confirm_code),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_func    (item_func),
        .item_typed   (item_typed),
        .item_confirm (item_confirm)
    );

    dlcc_fsm #(.CODE_W(CODE_W)) u_fsm
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_func    (item_func),
        .item_typed   (item_typed),
        .item_confirm (item_confirm),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res          (res)
    );

    assign response          = res.response;
    assign motor_drive       = res.motor_drive;
    assign alarm_sound       = res.alarm_sound;
    assign awaiting_new_code = res.awaiting_new_code;
    assign failed_tries      = res.failed_tries;

endmodule

FILE: rtl/dlcc_checker.sv
module dlcc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] response,
    input  logic [1:0] motor_drive,
    input  logic       alarm_sound,
    input  logic       awaiting_new_code,
    input  logic [2:0] failed_tries
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(response) && $stable(motor_drive)
            && $stable(alarm_sound) && $stable(awaiting_new_code) && $stable(failed_tries))
        else $error("result beat changed while stalled");

    // The motor code never takes the unused value.
    a_motor_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> motor_drive <= dlcc_pkg::MOTOR_BACKWARD)
        else $error("invalid motor drive code");

    // Alarm and setup are quiet modes: the motor is stopped in both, and they exclude each other.
    a_quiet_modes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (alarm_sound || awaiting_new_code)
            |-> motor_drive == dlcc_pkg::MOTOR_STOP && !(alarm_sound && awaiting_new_code))
        else $error("motor running or mode overlap in alarm or setup");

    // The wrong code that starts the alarm clears the failure count.
    a_alarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_sound && response == dlcc_pkg::RESP_MISMATCH
            |-> failed_tries == 3'd0)
        else $error("failure count not cleared when alarm starts");

endmodule

bind door_lock_code_controller_top dlcc_checker u_dlcc_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .response          (response),
    .motor_drive       (motor_drive),
    .alarm_sound       (alarm_sound),
    .awaiting_new_code (awaiting_new_code),
    .failed_tries      (failed_tries)
);
